FILE: hdl/msfc_pkg.sv
// ----------------------------------------------------------------------------
// msfc_pkg
// Shared widths, status codes and register indexes of the frame codec.
// ----------------------------------------------------------------------------
`default_nettype none

package msfc_pkg;

  // default sizes of the trailer field and the decode buffer
  localparam int MSFC_TRAILER_BYTES = 2;
  localparam int MSFC_BUF_DEPTH     = 17;

  // fixed field widths
  localparam int BYTE_W      = 8;
  localparam int SUM_W       = 7;
  localparam int CNT_W       = 5;
  localparam int ST_W        = 2;
  localparam int TOP_PER_TRL = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_CKSUM = 2'd1;
  localparam logic [ST_W-1:0] ST_LONG  = 2'd2;
  localparam logic [ST_W-1:0] ST_SHORT = 2'd3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ENC_ENCRYPT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_ENCRYPT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENC_CHECK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_CHECK   = 2'd3;

endpackage

`default_nettype wire

FILE: hdl/msfc_ifs.sv
// ----------------------------------------------------------------------------
// msfc_ifs
// Valid/ready channels of the frame codec: byte input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

// input channel: one frame byte per beat
interface msfc_in_if import msfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_end;

  modport source (output valid, output op, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input op, input data_byte, input frame_end, output ready);
endinterface

// result channel: one produced byte or status per beat
interface msfc_out_if import msfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_present;
  logic              out_last;
  logic [ST_W-1:0]   status;

  modport source (output valid, output out_byte, output byte_present, output out_last,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input byte_present, input out_last,
                  input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/msb_strip_frame_codec.sv
// Encode: a beat's registered result shows in the next cycle; one byte per cycle unless stalled.
// Encode end: TRAILER_BYTES trailers if stripping, checksum if checking; one per unstalled cycle.
// Decode: bytes go to the buffer at one per unstalled cycle; the last byte of a well-sized frame
// starts a scan over the buffer read port, then data comes out at one byte per unstalled cycle.
// Reset (rst_n, synchronous): config to defaults, frame state cleared; payload, buffer untouched.
// ----------------------------------------------------------------------------
// msb_strip_frame_codec
// Frame codec with top-bit stripping, trailer bytes and mod-128 checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_strip_frame_codec import msfc_pkg::*; #(
  parameter int TRAILER_BYTES       = MSFC_TRAILER_BYTES,
  parameter int DECODE_BUFFER_DEPTH = MSFC_BUF_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  msfc_in_if.sink                    in_ch,
  msfc_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(DECODE_BUFFER_DEPTH);
  localparam int TBITS = TOP_PER_TRL * TRAILER_BYTES;
  localparam int TIW   = $clog2(TBITS);

  localparam logic [CNT_W-1:0] TB_CNT    = CNT_W'(TRAILER_BYTES);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DECODE_BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] TBITS_CNT = CNT_W'(TBITS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ETAIL = 5'b00010,
    S_SCAN  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_STAT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic enc_encrypt_r, dec_encrypt_r, enc_check_r, dec_check_r;

  // frame state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [TBITS-1:0] trl_r, trl_nxt;
  logic             ovf_r, ovf_nxt;

  // sequencer
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [ST_W-1:0]  stat_r, stat_nxt;
  logic             q_vld_r, q_vld_nxt;
  logic [CNT_W-1:0] q_idx_r, q_idx_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              op_r, op_nxt;
  logic              ol_r, ol_nxt;
  logic [ST_W-1:0]   os_r, os_nxt;

  // buffer port
  logic              buf_we, buf_re;
  logic [AW-1:0]     buf_waddr, buf_raddr;
  logic [BYTE_W-1:0] buf_q;

  logic              out_free, acc, consume;
  logic [BYTE_W-1:0] enc_ob;
  logic [CNT_W-1:0]  dec_len, dec_t, dec_c, dec_n;
  logic              dec_ovf;

  msfc_fbuf #(
    .DEPTH (DECODE_BUFFER_DEPTH),
    .AW    (AW)
  ) u_fbuf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (in_ch.data_byte),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_q)
  );

  // handshake
  assign out_free    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign acc         = in_ch.valid && in_ch.ready;
  assign consume     = q_vld_r && out_free;

  assign out_ch.valid        = ov_r;
  assign out_ch.out_byte     = ob_r;
  assign out_ch.byte_present = op_r;
  assign out_ch.out_last     = ol_r;
  assign out_ch.status       = os_r;

  // encoded byte: with stripping on, the first byte marks the frame start and later ones lose bit 7
  always_comb begin
    enc_ob = in_ch.data_byte;
    if (enc_encrypt_r) begin
      enc_ob = (cnt_r == '0) ? {1'b1, in_ch.data_byte[6:0]} : {1'b0, in_ch.data_byte[6:0]};
    end
  end

  // decode frame sizing at the last byte
  assign dec_ovf = ovf_r || (cnt_r >= DEPTH_CNT);
  assign dec_len = (cnt_r < DEPTH_CNT) ? cnt_r + 1'b1 : cnt_r;
  assign dec_c   = dec_check_r ? CNT_W'(1) : '0;
  assign dec_t   = dec_encrypt_r ? TB_CNT : '0;
  assign dec_n   = dec_len - dec_c - dec_t;

  // control and datapath
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    trl_nxt   = trl_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    stat_nxt  = stat_r;
    q_vld_nxt = q_vld_r;
    q_idx_nxt = q_idx_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ob_nxt    = ob_r;
    op_nxt    = op_r;
    ol_nxt    = ol_r;
    os_nxt    = os_r;
    buf_we    = 1'b0;
    buf_waddr = cnt_r[AW-1:0];
    buf_re    = 1'b0;
    buf_raddr = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (acc && !in_ch.op) begin
          // encode beat: stream the byte, note its top bit when stripping
          if (enc_encrypt_r) begin
            if (cnt_r < TBITS_CNT) begin
              if (in_ch.data_byte[7]) begin
                trl_nxt[cnt_r[TIW-1:0]] = 1'b1;
              end
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          sum_nxt = sum_r + enc_ob[SUM_W-1:0];
          cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
          ov_nxt  = 1'b1;
          ob_nxt  = enc_ob;
          op_nxt  = 1'b1;
          ol_nxt  = in_ch.frame_end && !enc_encrypt_r && !enc_check_r;
          os_nxt  = ST_OK;
          if (in_ch.frame_end) begin
            if (enc_encrypt_r || enc_check_r) begin
              state_nxt = S_ETAIL;
              idx_nxt   = '0;
            end else begin
              os_nxt  = ovf_nxt ? ST_LONG : ST_OK;
              cnt_nxt = '0;
              sum_nxt = '0;
              trl_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end
        end else if (acc) begin
          // decode beat: store the byte if the buffer has room
          if (cnt_r < DEPTH_CNT) begin
            buf_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.frame_end) begin
            n_nxt     = dec_n;
            sum_nxt   = '0;
            idx_nxt   = '0;
            q_vld_nxt = 1'b0;
            stat_nxt  = ST_OK;
            state_nxt = S_SCAN;
            if (dec_ovf || dec_len > DEPTH_CNT) begin
              stat_nxt  = ST_LONG;
              state_nxt = S_STAT;
            end else if (dec_len < dec_c + dec_t) begin
              stat_nxt  = ST_SHORT;
              state_nxt = S_STAT;
            end else if (dec_encrypt_r && dec_n > TBITS_CNT) begin
              stat_nxt  = ST_LONG;
              state_nxt = S_STAT;
            end
          end
        end
      end

      S_ETAIL: begin
        // trailer bytes when stripping, then the checksum when checking
        if (out_free) begin
          ov_nxt  = 1'b1;
          op_nxt  = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (enc_encrypt_r && idx_r < TB_CNT) begin
            ob_nxt  = {1'b0, trl_r[SUM_W-1:0]};
            sum_nxt = sum_r + trl_r[SUM_W-1:0];
            trl_nxt = trl_r >> TOP_PER_TRL;
            ol_nxt  = (idx_r == TB_CNT - 1'b1) && !enc_check_r;
          end else begin
            ob_nxt = {1'b0, sum_r};
            ol_nxt = 1'b1;
          end
          os_nxt = (ol_nxt && ovf_r) ? ST_LONG : ST_OK;
          if (ol_nxt) begin
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            trl_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // read the whole frame once: checksum and trailer capture
        if (idx_r < cnt_r) begin
          buf_re    = 1'b1;
          q_vld_nxt = 1'b1;
          q_idx_nxt = idx_r;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          q_vld_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = (n_r == '0) ? S_STAT : S_EMIT;
        end
        if (q_vld_r) begin
          if ({1'b0, q_idx_r} + 1'b1 < {1'b0, cnt_r}) begin
            sum_nxt = sum_r + buf_q[SUM_W-1:0];
          end else if (dec_check_r && ({1'b0, sum_r} != buf_q)) begin
            stat_nxt = ST_CKSUM;
          end
          if (dec_encrypt_r) begin
            for (int k = 0; k < TRAILER_BYTES; k++) begin
              if ({1'b0, q_idx_r} == {1'b0, n_r} + (CNT_W+1)'(k)) begin
                trl_nxt[k*TOP_PER_TRL +: TOP_PER_TRL] = buf_q[SUM_W-1:0];
              end
            end
          end
        end
      end

      S_EMIT: begin
        // data bytes, with top bits restored when stripping
        if (consume) begin
          ov_nxt = 1'b1;
          op_nxt = 1'b1;
          ob_nxt = dec_encrypt_r ? {trl_r[q_idx_r[TIW-1:0]], buf_q[SUM_W-1:0]} : buf_q;
          ol_nxt = (q_idx_r + 1'b1 == n_r);
          os_nxt = ol_nxt ? stat_r : ST_OK;
          q_vld_nxt = 1'b0;
          if (ol_nxt) begin
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            trl_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
        if (idx_r < n_r && (!q_vld_r || consume)) begin
          buf_re    = 1'b1;
          q_vld_nxt = 1'b1;
          q_idx_nxt = idx_r;
          idx_nxt   = idx_r + 1'b1;
        end
      end

      S_STAT: begin
        // status-only closing beat
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = '0;
          op_nxt    = 1'b0;
          ol_nxt    = 1'b1;
          os_nxt    = stat_r;
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          trl_nxt   = '0;
          ovf_nxt   = 1'b0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_encrypt_r <= 1'b1;
      dec_encrypt_r <= 1'b0;
      enc_check_r   <= 1'b1;
      dec_check_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ENC_ENCRYPT: enc_encrypt_r <= cfg_wdata[0];
        REG_DEC_ENCRYPT: dec_encrypt_r <= cfg_wdata[0];
        REG_ENC_CHECK:   enc_check_r   <= cfg_wdata[0];
        REG_DEC_CHECK:   dec_check_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      trl_r   <= '0;
      ovf_r   <= 1'b0;
      q_vld_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      trl_r   <= trl_nxt;
      ovf_r   <= ovf_nxt;
      q_vld_r <= q_vld_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload and sequencer registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    n_r     <= n_nxt;
    stat_r  <= stat_nxt;
    q_idx_r <= q_idx_nxt;
    ob_r    <= ob_nxt;
    op_r    <= op_nxt;
    ol_r    <= ol_nxt;
    os_r    <= os_nxt;
  end

  // buffer reads are only in flight during scan and emission
  a_qvld_state: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld_r |-> (state_r == S_SCAN || state_r == S_EMIT))
    else $error("buffer read in flight outside scan or emission");

  // emitted reads stay inside the data part
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (q_vld_r && state_r == S_EMIT) |-> (q_idx_r < n_r))
    else $error("emission read beyond the data part");

  // status is carried only by the last result of a frame
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ol_r) |-> (os_r == ST_OK))
    else $error("status on a result that is not the last");

  // a status-only result always closes a frame
  a_statonly_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !op_r) |-> (ol_r && ob_r == '0))
    else $error("status-only result is not a frame end");

endmodule

`default_nettype wire

FILE: hdl/msfc_fbuf.sv
// ----------------------------------------------------------------------------
// msfc_fbuf
// Decode frame buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msfc_fbuf import msfc_pkg::*; #(
  parameter int DEPTH = MSFC_BUF_DEPTH,
  parameter int AW    = $clog2(MSFC_BUF_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: verif/msfc_tb_pkg.sv
// ----------------------------------------------------------------------------
// msfc_tb_pkg
// Direction codes shared by the frame codec stimulus and its result checker.
// ----------------------------------------------------------------------------
`default_nettype none

package msfc_tb_pkg;

  // direction of a frame byte
  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } codec_op_e;

endpackage

`default_nettype wire

FILE: verif/msfc_result_checker.sv
// ----------------------------------------------------------------------------
// msfc_result_checker
// Watches the byte and result channels of the frame codec, models the
// encode and decode paths beat by beat and compares every result beat
// with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module msfc_result_checker import msfc_pkg::*, msfc_tb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  msfc_in_if                         in_ch,
  msfc_out_if                        out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         mismatch_count,
  output int                         results_due
);

  localparam int TRAILER_CAP = MSFC_TRAILER_BYTES * TOP_PER_TRL;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              last;
    logic [ST_W-1:0]   status;
  } result_beat_t;

  // mode registers
  bit strip_enc;
  bit strip_dec;
  bit sum_enc;
  bit sum_dec;

  // per-frame state
  logic [CNT_W-1:0]  frame_len;
  logic [SUM_W-1:0]  frame_sum;
  logic [SUM_W-1:0]  top_bits [MSFC_TRAILER_BYTES];
  logic [BYTE_W-1:0] rx_frame [MSFC_BUF_DEPTH];
  logic              too_long;

  result_beat_t due_results[$];
  result_beat_t got;
  result_beat_t want;

  // work out the result beats caused by one input beat
  task automatic predict_codec_beats(input logic op, input logic [BYTE_W-1:0] din,
                                     input logic fend);
    result_beat_t      burst[$];
    logic [BYTE_W-1:0] ob;
    logic [SUM_W-1:0]  sum;
    logic [ST_W-1:0]   st;
    int                len;
    int                n;
    int                ck;
    int                nt;
    int                i;
    st = ST_OK;
    if (op == OP_ENCODE) begin
      ob = din;
      // first byte carries the start mark, top bits go to the trailers
      if (strip_enc) begin
        ob[BYTE_W-1] = (frame_len == 0);
        if (frame_len < TRAILER_CAP) begin
          top_bits[frame_len / TOP_PER_TRL][frame_len % TOP_PER_TRL] =
            top_bits[frame_len / TOP_PER_TRL][frame_len % TOP_PER_TRL] | din[BYTE_W-1];
        end else begin
          too_long = 1'b1;
        end
      end
      frame_sum = frame_sum + ob[SUM_W-1:0];
      burst.push_back('{ob, 1'b1, 1'b0, ST_OK});
      if (frame_len != CNT_MAX) frame_len = frame_len + 1'b1;
      if (fend) begin
        if (strip_enc) begin
          for (i = 0; i < MSFC_TRAILER_BYTES; i++) begin
            frame_sum = frame_sum + top_bits[i];
            burst.push_back('{{1'b0, top_bits[i]}, 1'b1, 1'b0, ST_OK});
          end
        end
        if (sum_enc) burst.push_back('{{1'b0, frame_sum}, 1'b1, 1'b0, ST_OK});
        if (too_long) st = ST_LONG;
      end
    end else begin
      if (frame_len < MSFC_BUF_DEPTH) begin
        rx_frame[frame_len] = din;
        frame_len = frame_len + 1'b1;
      end else begin
        too_long = 1'b1;
      end
      if (fend) begin
        len = frame_len;
        ck  = sum_dec ? 1 : 0;
        nt  = strip_dec ? MSFC_TRAILER_BYTES : 0;
        if (too_long || len > MSFC_BUF_DEPTH) begin
          st = ST_LONG;
        end else if (len < ck + nt) begin
          st = ST_SHORT;
        end else if (strip_dec && (len - ck - nt) > TRAILER_CAP) begin
          st = ST_LONG;
        end else begin
          n = len - ck - nt;
          // checksum covers every byte before it, top bits ignored
          if (sum_dec) begin
            sum = '0;
            for (i = 0; i < len - 1; i++) sum = sum + rx_frame[i][SUM_W-1:0];
            if ({1'b0, sum} != rx_frame[len-1]) st = ST_CKSUM;
          end
          for (i = 0; i < n; i++) begin
            ob = rx_frame[i];
            if (strip_dec) ob[BYTE_W-1] = rx_frame[n + i / TOP_PER_TRL][i % TOP_PER_TRL];
            burst.push_back('{ob, 1'b1, 1'b0, ST_OK});
          end
        end
      end
    end
    // frame end closes the burst and clears the frame state
    if (fend) begin
      if (burst.size() == 0) burst.push_back('{'0, 1'b0, 1'b0, ST_OK});
      burst[burst.size()-1].last   = 1'b1;
      burst[burst.size()-1].status = st;
      frame_len = '0;
      frame_sum = '0;
      too_long  = 1'b0;
      top_bits  = '{default: '0};
    end
    foreach (burst[k]) due_results.push_back(burst[k]);
  endtask

  // sample both channels and the register port at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      strip_enc = 1'b1;
      strip_dec = 1'b0;
      sum_enc   = 1'b1;
      sum_dec   = 1'b1;
      frame_len = '0;
      frame_sum = '0;
      too_long  = 1'b0;
      top_bits  = '{default: '0};
      due_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ENC_ENCRYPT: strip_enc = cfg_wdata[0];
          REG_DEC_ENCRYPT: strip_dec = cfg_wdata[0];
          REG_ENC_CHECK:   sum_enc   = cfg_wdata[0];
          REG_DEC_CHECK:   sum_dec   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_codec_beats(in_ch.op, in_ch.data_byte, in_ch.frame_end);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_byte, out_ch.byte_present, out_ch.out_last, out_ch.status};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result beat: byte %02h present %0b last %0b status %0d",
                   $time, got.data, got.present, got.last, got.status);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected byte %02h present %0b last %0b status %0d",
                     $time, want.data, want.present, want.last, want.status);
            $display("%0t:                   actual byte %02h present %0b last %0b status %0d",
                     $time, got.data, got.present, got.last, got.status);
            mismatch_count++;
          end
        end
      end
    end
    results_due = due_results.size();
  end

endmodule

`default_nettype wire

FILE: verif/msb_strip_frame_codec_tb.sv
// ----------------------------------------------------------------------------
// msb_strip_frame_codec_tb
// Drives encode, decode and mixed frames through the frame codec under a
// range of mode settings, with random idling on both channels and long
// receiver stalls; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_strip_frame_codec_tb;
  import msfc_pkg::*;
  import msfc_tb_pkg::*;

  localparam int TRAILER_CAP     = MSFC_TRAILER_BYTES * TOP_PER_TRL;
  localparam int MAX_GAP         = 17;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 250;
  localparam int IDLE_LIMIT      = 2000;
  localparam int BEATS_PER_PHASE = 32;
  localparam int PHASES          = 8;
  localparam int RANDOM_PHASE    = 6;

  // mode bits per phase: {encode strip, decode strip, encode check, decode check}
  localparam logic [3:0] PHASE_MODES [PHASES] = '{
    4'b1111, 4'b0000, 4'b1101, 4'b0110, 4'b1010, 4'b0101, 4'b1111, 4'b1011
  };

  typedef struct packed {
    codec_op_e         op;
    logic [BYTE_W-1:0] data;
  } frame_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit dec_strip;
  bit dec_check;
  bit src_burst;
  bit snk_burst;
  bit sink_hold;

  int mismatches;
  int results_due;
  int idle_cycles;
  int phase_beats;

  frame_beat_t frame_q[$];

  msfc_in_if  in_ch ();
  msfc_out_if out_ch ();

  msb_strip_frame_codec uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  msfc_result_checker u_result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatches),
    .results_due    (results_due)
  );

  always #4 clk = ~clk;

  // one byte beat, after a random gap unless bursting
  task automatic send_beat(input frame_beat_t beat, input logic fend);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= beat.op;
    in_ch.data_byte <= beat.data;
    in_ch.frame_end <= fend;
    do @(posedge clk); while (!in_ch.ready);
    phase_beats++;
  endtask

  // send the queued frame, marking its last byte
  task automatic send_frame();
    foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // stop offering and wait for every predicted result, then settle
  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    wait (results_due == 0);
    repeat (extra) @(posedge clk);
  endtask

  // write all four mode registers, one per cycle
  task automatic set_modes(input logic [3:0] m);
    logic [CFG_IDX_W-1:0] regs [4];
    int                   r;
    regs = '{REG_ENC_ENCRYPT, REG_DEC_ENCRYPT, REG_ENC_CHECK, REG_DEC_CHECK};
    for (r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[r];
      cfg_wdata <= m[3-r];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    dec_strip = m[2];
    dec_check = m[0];
  endtask

  // receiver: random hold-off per result beat, long stall on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
      gap = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("msb_strip_frame_codec test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [BYTE_W-1:0] b;
    logic [SUM_W-1:0]  sum7;
    logic [SUM_W-1:0]  trl [MSFC_TRAILER_BYTES];
    logic [3:0]        modes;
    int                p;
    int                i;
    int                n;
    int                len;
    int                kind;
    int                r;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_ENC_ENCRYPT;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_ENCODE;
    in_ch.data_byte = '0;
    in_ch.frame_end = 1'b0;
    dec_strip       = 1'b0;
    dec_check       = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decode frame past the buffer depth: fills every entry, ends too long
    for (i = 0; i <= MSFC_BUF_DEPTH; i++) begin
      frame_q.push_back('{OP_DECODE, 8'($urandom_range(0, 255))});
    end
    send_frame();
    // single zero byte gets the start mark
    frame_q.push_back('{OP_ENCODE, 8'h00});
    send_frame();
    // top bits set and clear after the first byte
    frame_q.push_back('{OP_ENCODE, 8'hFF});
    frame_q.push_back('{OP_ENCODE, 8'h7F});
    frame_q.push_back('{OP_ENCODE, 8'h80});
    send_frame();
    // checksum only, no data
    frame_q.push_back('{OP_DECODE, 8'h00});
    send_frame();
    // bad checksum, data still comes out
    frame_q.push_back('{OP_DECODE, 8'h85});
    frame_q.push_back('{OP_DECODE, 8'h06});
    send_frame();
    drain(SETTLE_CYCLES);

    for (p = 0; p < PHASES; p++) begin
      modes = (p == RANDOM_PHASE) ? 4'($urandom_range(0, 15)) : PHASE_MODES[p];
      set_modes(modes);
      phase_beats = 0;
      // long receiver stall while frames keep coming
      if (p == 2 || p == 5) sink_hold = 1'b1;
      while (phase_beats < BEATS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          // encode frame, sometimes past the trailer reach or the counter limit
          r = $urandom_range(0, 99);
          if (r < 70)      len = $urandom_range(1, 8);
          else if (r < 90) len = $urandom_range(9, 16);
          else if (r < 98) len = $urandom_range(17, 22);
          else             len = $urandom_range(32, 35);
          for (i = 0; i < len; i++) begin
            frame_q.push_back('{OP_ENCODE, 8'($urandom_range(0, 255))});
          end
        end else if (kind < 75) begin
          // decode frame for the current modes, now and then with a corrupted checksum
          n = ($urandom_range(0, 3) == 0) ?
              $urandom_range(0, dec_strip ? TRAILER_CAP : MSFC_BUF_DEPTH - 1) :
              $urandom_range(0, 6);
          trl  = '{default: '0};
          sum7 = '0;
          for (i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (dec_strip) begin
              trl[i / TOP_PER_TRL][i % TOP_PER_TRL] = b[BYTE_W-1];
              b[BYTE_W-1] = (i == 0);
            end
            sum7 = sum7 + b[SUM_W-1:0];
            frame_q.push_back('{OP_DECODE, b});
          end
          if (dec_strip) begin
            for (i = 0; i < MSFC_TRAILER_BYTES; i++) begin
              sum7 = sum7 + trl[i];
              frame_q.push_back('{OP_DECODE, {1'b0, trl[i]}});
            end
          end
          if (dec_check) begin
            b = {1'b0, sum7};
            if ($urandom_range(0, 7) == 0) b = b ^ 8'($urandom_range(1, 255));
            frame_q.push_back('{OP_DECODE, b});
          end
          if (frame_q.size() == 0) begin
            frame_q.push_back('{OP_DECODE, 8'($urandom_range(0, 255))});
          end
        end else if (kind < 90) begin
          // random decode bytes: short, long or bad frames
          len = $urandom_range(1, 20);
          for (i = 0; i < len; i++) begin
            frame_q.push_back('{OP_DECODE, 8'($urandom_range(0, 255))});
          end
        end else begin
          // directions mixed within one frame
          len = $urandom_range(1, 10);
          for (i = 0; i < len; i++) begin
            frame_q.push_back('{codec_op_e'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255))});
          end
        end
        src_burst = ($urandom_range(0, 3) == 0);
        send_frame();
        // sender pause until the block has emptied
        if ($urandom_range(0, 15) == 0) drain(1);
      end
      drain(SETTLE_CYCLES);
    end

    if (mismatches == 0 && results_due == 0) begin
      $display("msb_strip_frame_codec test passed");
    end else begin
      $display("msb_strip_frame_codec test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
